// ===== src/fsd_pkg.sv =====
// shared types and constants for the flight stage detector
package fsd_pkg;

    // widths of time stamps and fixed point quantities
    localparam int TIME_WIDTH = 32;
    localparam int FRAC_BITS  = 8;
    localparam int ACC_WIDTH  = 24;
    localparam int SPD_WIDTH  = 23;
    localparam int STG_WIDTH  = 3;
    localparam int IDX_WIDTH  = 3;
    localparam int DAT_WIDTH  = 32;

    // stage codes
    localparam logic [STG_WIDTH-1:0] ST_UNINIT  = 3'd0;
    localparam logic [STG_WIDTH-1:0] ST_PAD     = 3'd1;
    localparam logic [STG_WIDTH-1:0] ST_BOOST   = 3'd2;
    localparam logic [STG_WIDTH-1:0] ST_COAST   = 3'd3;
    localparam logic [STG_WIDTH-1:0] ST_APOGEE  = 3'd4;
    localparam logic [STG_WIDTH-1:0] ST_DESCENT = 3'd5;
    localparam logic [STG_WIDTH-1:0] ST_LANDED  = 3'd6;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FORCE  = 1'b1;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_BOOST_ACCEL   = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_LIFTOFF_TIME  = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BURNOUT_ACCEL = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_BURNOUT_TIME  = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_APOGEE_SPEED  = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_DESCENT_SPEED = 3'd5;
    localparam logic [IDX_WIDTH-1:0] REG_LANDING_SPEED = 3'd6;
    localparam logic [IDX_WIDTH-1:0] REG_LANDING_TIME  = 3'd7;

    // register reset values
    localparam logic signed [ACC_WIDTH-1:0] RST_BOOST_ACCEL   = 24'sd30 <<< FRAC_BITS;
    localparam logic [TIME_WIDTH-1:0]       RST_LIFTOFF_TIME  = 32'd100000;
    localparam logic signed [ACC_WIDTH-1:0] RST_BURNOUT_ACCEL = 24'sd0;
    localparam logic [TIME_WIDTH-1:0]       RST_BURNOUT_TIME  = 32'd100000;
    localparam logic [SPD_WIDTH-1:0]        RST_APOGEE_SPEED  = 23'd2 << FRAC_BITS;
    localparam logic signed [ACC_WIDTH-1:0] RST_DESCENT_SPEED = -(24'sd2 <<< FRAC_BITS);
    localparam logic [SPD_WIDTH-1:0]        RST_LANDING_SPEED = 23'd1 << FRAC_BITS;
    localparam logic [TIME_WIDTH-1:0]       RST_LANDING_TIME  = 32'd2000000;

    // configuration set
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] boost_accel;
        logic [TIME_WIDTH-1:0]       liftoff_time;
        logic signed [ACC_WIDTH-1:0] burnout_accel;
        logic [TIME_WIDTH-1:0]       burnout_time;
        logic [SPD_WIDTH-1:0]        apogee_speed;
        logic signed [ACC_WIDTH-1:0] descent_speed;
        logic [SPD_WIDTH-1:0]        landing_speed;
        logic [TIME_WIDTH-1:0]       landing_time;
    } t_cfg;

    // one input item
    typedef struct packed {
        logic                        op;
        logic [TIME_WIDTH-1:0]       time_us;
        logic signed [ACC_WIDTH-1:0] accel_z;
        logic signed [ACC_WIDTH-1:0] vel_z;
        logic [STG_WIDTH-1:0]        new_stage;
    } t_item;

endpackage

// ===== src/flight_stage_detector_top.sv =====
// top level of the flight stage detector: input and result registers around the core
//
// One item is taken per clock cycle unless the output stalls. An accepted item sits
// in the input register, the stage logic decides its result in the following cycle and
// the result register captures and presents it, so a fresh item may follow every cycle
// while the output keeps up; the result register decouples the two
// channels, and only a stalled output with both registers full holds the input.
// The stage transition logic and its stage register set this one-item-per-cycle
// figure. Configuration writes take effect at once and are meant for idle periods.
module flight_stage_detector_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fsd_pkg::IDX_WIDTH-1:0]         i_cfg_index,
    input  logic [fsd_pkg::DAT_WIDTH-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_op,
    input  logic [fsd_pkg::TIME_WIDTH-1:0]        i_time_us,
    input  logic signed [fsd_pkg::ACC_WIDTH-1:0]  i_accel_z,
    input  logic signed [fsd_pkg::ACC_WIDTH-1:0]  i_vel_z,
    input  logic [fsd_pkg::STG_WIDTH-1:0]         i_new_stage,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [fsd_pkg::STG_WIDTH-1:0]         o_stage,
    output logic                                  o_changed
);
    import fsd_pkg::*;

    t_cfg                 cfg;
    t_item                r_item;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic [STG_WIDTH-1:0] r_stage;
    logic                 r_changed;
    logic [STG_WIDTH-1:0] core_stage;
    logic                 core_changed;
    logic                 advance;

    // item moves to the result register when that register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    fsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_item    (r_item),
        .i_commit  (advance),
        .o_stage   (core_stage),
        .o_changed (core_changed)
    );

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.op        <= i_op;
            r_item.time_us   <= i_time_us;
            r_item.accel_z   <= i_accel_z;
            r_item.vel_z     <= i_vel_z;
            r_item.new_stage <= i_new_stage;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_stage   <= core_stage;
            r_changed <= core_changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_stage     = r_stage;
    assign o_changed   = r_changed;

endmodule

// ===== src/fsd_cfg.sv =====
// configuration registers of the flight stage detector
module fsd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fsd_pkg::IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [fsd_pkg::DAT_WIDTH-1:0]  i_cfg_data,
    output fsd_pkg::t_cfg                  o_cfg
);
    import fsd_pkg::*;

    t_cfg r_cfg;

    // register writes, low bits of the data taken for narrower registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.boost_accel   <= RST_BOOST_ACCEL;
            r_cfg.liftoff_time  <= RST_LIFTOFF_TIME;
            r_cfg.burnout_accel <= RST_BURNOUT_ACCEL;
            r_cfg.burnout_time  <= RST_BURNOUT_TIME;
            r_cfg.apogee_speed  <= RST_APOGEE_SPEED;
            r_cfg.descent_speed <= RST_DESCENT_SPEED;
            r_cfg.landing_speed <= RST_LANDING_SPEED;
            r_cfg.landing_time  <= RST_LANDING_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOOST_ACCEL:   r_cfg.boost_accel   <= i_cfg_data[ACC_WIDTH-1:0];
                REG_LIFTOFF_TIME:  r_cfg.liftoff_time  <= i_cfg_data[TIME_WIDTH-1:0];
                REG_BURNOUT_ACCEL: r_cfg.burnout_accel <= i_cfg_data[ACC_WIDTH-1:0];
                REG_BURNOUT_TIME:  r_cfg.burnout_time  <= i_cfg_data[TIME_WIDTH-1:0];
                REG_APOGEE_SPEED:  r_cfg.apogee_speed  <= i_cfg_data[SPD_WIDTH-1:0];
                REG_DESCENT_SPEED: r_cfg.descent_speed <= i_cfg_data[ACC_WIDTH-1:0];
                REG_LANDING_SPEED: r_cfg.landing_speed <= i_cfg_data[SPD_WIDTH-1:0];
                REG_LANDING_TIME:  r_cfg.landing_time  <= i_cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/fsd_core.sv =====
// stage state, start time latches and transition logic
module fsd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fsd_pkg::t_cfg                  i_cfg,
    input  fsd_pkg::t_item                 i_item,
    input  logic                           i_commit,
    output logic [fsd_pkg::STG_WIDTH-1:0]  o_stage,
    output logic                           o_changed
);
    import fsd_pkg::*;

    logic [STG_WIDTH-1:0]  r_stage, n_stage;
    logic [TIME_WIDTH-1:0] r_boost_start, r_coast_start, r_landing_start;
    logic                  r_boost_seen, r_coast_seen, r_landing_seen;
    logic                  n_boost_seen, n_coast_seen, n_landing_seen;

    logic [ACC_WIDTH-1:0]  vel_mag;
    logic [TIME_WIDTH-1:0] boost_el, coast_el, landing_el;
    logic                  boost_cond, coast_cond, apogee_cond, descent_cond, landing_cond;

    // qualifying conditions, magnitude kept exact for the most negative velocity
    assign vel_mag      = i_item.vel_z[ACC_WIDTH-1] ? (~i_item.vel_z + 1'b1) : i_item.vel_z;
    assign boost_cond   = i_item.accel_z > i_cfg.boost_accel;
    assign coast_cond   = i_item.accel_z <= i_cfg.burnout_accel;
    assign apogee_cond  = vel_mag < {1'b0, i_cfg.apogee_speed};
    assign descent_cond = i_item.vel_z < i_cfg.descent_speed;
    assign landing_cond = vel_mag < {1'b0, i_cfg.landing_speed};

    // wrapping elapsed times
    assign boost_el   = i_item.time_us - r_boost_start;
    assign coast_el   = i_item.time_us - r_coast_start;
    assign landing_el = i_item.time_us - r_landing_start;

    // next stage and latch flags
    always_comb begin
        n_stage        = r_stage;
        n_boost_seen   = r_boost_seen;
        n_coast_seen   = r_coast_seen;
        n_landing_seen = r_landing_seen;
        if (i_item.op == OP_FORCE) begin
            if (i_item.new_stage <= ST_LANDED) begin
                n_stage = i_item.new_stage;
            end
        end else begin
            case (r_stage)
                ST_PAD: begin
                    if (boost_cond) begin
                        if (!r_boost_seen) begin
                            n_boost_seen = 1'b1;
                        end else if (boost_el > i_cfg.liftoff_time) begin
                            n_stage = ST_BOOST;
                        end
                    end
                end
                ST_BOOST: begin
                    if (coast_cond) begin
                        if (!r_coast_seen) begin
                            n_coast_seen = 1'b1;
                        end else if (coast_el > i_cfg.burnout_time) begin
                            n_stage = ST_COAST;
                        end
                    end
                end
                ST_COAST: begin
                    if (apogee_cond) begin
                        n_stage = ST_APOGEE;
                    end
                end
                ST_APOGEE: begin
                    if (descent_cond) begin
                        n_stage = ST_DESCENT;
                    end
                end
                ST_DESCENT: begin
                    if (landing_cond) begin
                        if (!r_landing_seen) begin
                            n_landing_seen = 1'b1;
                        end else if (landing_el > i_cfg.landing_time) begin
                            n_stage = ST_LANDED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state update on commit of an item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage         <= ST_UNINIT;
            r_boost_seen    <= 1'b0;
            r_coast_seen    <= 1'b0;
            r_landing_seen  <= 1'b0;
            r_boost_start   <= '0;
            r_coast_start   <= '0;
            r_landing_start <= '0;
        end else if (i_commit) begin
            r_stage        <= n_stage;
            r_boost_seen   <= n_boost_seen;
            r_coast_seen   <= n_coast_seen;
            r_landing_seen <= n_landing_seen;
            if (n_boost_seen && !r_boost_seen) begin
                r_boost_start <= i_item.time_us;
            end
            if (n_coast_seen && !r_coast_seen) begin
                r_coast_start <= i_item.time_us;
            end
            if (n_landing_seen && !r_landing_seen) begin
                r_landing_start <= i_item.time_us;
            end
        end
    end

    assign o_stage   = n_stage;
    assign o_changed = n_stage != r_stage;

    // latches never clear outside reset
    a_boost_seen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boost_seen |=> r_boost_seen)
        else $error("boost latch cleared");

    a_landing_seen_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_landing_seen |=> r_landing_seen)
        else $error("landing latch cleared");

    // a sample reaches boost only from pad with the latch already set
    a_boost_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.op == OP_SAMPLE && n_stage == ST_BOOST && r_stage != ST_BOOST)
        |-> (r_stage == ST_PAD && r_boost_seen))
        else $error("boost entered without pad qualification");

    // stage holds while no item commits
    a_stage_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit |=> $stable(r_stage))
        else $error("stage moved without an item");

endmodule

// ===== bench/tb.sv =====
// self-checking bench for flight_stage_detector_top: a scripted flight, random flights, threshold sweeps
`timescale 1ns / 1ps

module tb;
    import fsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam longint      VAL_MAX     = 8388607;
    localparam longint      VAL_MIN     = -8388608;
    localparam logic [STG_WIDTH-1:0] ST_NO_SUCH = 3'd7;

    typedef struct packed {
        logic [STG_WIDTH-1:0] stage;
        logic                 changed;
    } t_stage_report;

    // clock, reset and block inputs, all known from time zero
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [IDX_WIDTH-1:0]        i_cfg_index = '0;
    logic [DAT_WIDTH-1:0]        i_cfg_data  = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        i_op        = OP_SAMPLE;
    logic [TIME_WIDTH-1:0]       i_time_us   = '0;
    logic signed [ACC_WIDTH-1:0] i_accel_z   = '0;
    logic signed [ACC_WIDTH-1:0] i_vel_z     = '0;
    logic [STG_WIDTH-1:0]        i_new_stage = '0;
    logic                        i_out_ready = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic [STG_WIDTH-1:0]        o_stage;
    logic                        o_changed;

    // stimulus and expectation stores
    t_item         flight_items_q[$];
    t_stage_report stage_reports_q[$];
    t_item         item_on_bus;
    bit            no_gaps = 1'b0;

    // predictor copy of thresholds and detector state
    t_cfg                  limits;
    logic [STG_WIDTH-1:0]  stage_now      = ST_UNINIT;
    logic [TIME_WIDTH-1:0] boost_t0       = '0;
    logic [TIME_WIDTH-1:0] burnout_t0     = '0;
    logic [TIME_WIDTH-1:0] touchdown_t0   = '0;
    bit                    boost_armed     = 1'b0;
    bit                    burnout_armed   = 1'b0;
    bit                    touchdown_armed = 1'b0;

    // generator time base and run statistics
    logic [TIME_WIDTH-1:0] mission_us = '0;
    int unsigned           cycle_count     = 0;
    int unsigned           mismatch_count  = 0;
    int unsigned           items_taken     = 0;
    int unsigned           results_checked = 0;
    int unsigned           stage_changes   = 0;
    logic [7:0]            stages_reached  = '0;

    flight_stage_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_time_us   (i_time_us),
        .i_accel_z   (i_accel_z),
        .i_vel_z     (i_vel_z),
        .i_new_stage (i_new_stage),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_stage     (o_stage),
        .o_changed   (o_changed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit odds(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic longint pick_span(input longint lo, input longint hi);
        if (hi <= lo) return lo;
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic longint any_value();
        return pick_span(VAL_MIN, VAL_MAX);
    endfunction

    // acceleration strictly above a threshold, often just above it; any value when the threshold is the maximum
    function automatic longint accel_over(input longint thr);
        if (thr >= VAL_MAX) return any_value();
        if (odds(30)) return thr + 1;
        return pick_span(thr + 1, VAL_MAX);
    endfunction

    function automatic longint accel_not_over(input longint thr);
        if (odds(30)) return thr;
        return pick_span(VAL_MIN, thr);
    endfunction

    // velocity with magnitude under a speed limit, or any value when the limit is zero
    function automatic longint vel_slow(input longint spd);
        if (spd == 0) return any_value();
        case ($urandom_range(3))
            0: return spd - 1;
            1: return -(spd - 1);
            default: return pick_span(-(spd - 1), spd - 1);
        endcase
    endfunction

    function automatic longint vel_fast(input longint spd);
        case ($urandom_range(7))
            0: return spd;
            1: return -spd;
            2: return VAL_MIN;
            default: return odds(50) ? pick_span(spd, VAL_MAX) : pick_span(VAL_MIN, -spd);
        endcase
    endfunction

    function automatic longint vel_below(input longint lim);
        if (lim <= VAL_MIN) return any_value();
        if (odds(30)) return lim - 1;
        return pick_span(VAL_MIN, lim - 1);
    endfunction

    function automatic longint vel_not_below(input longint lim);
        if (odds(30)) return lim;
        return pick_span(lim, VAL_MAX);
    endfunction

    // time advance sized so that a duration is crossed within a few samples
    function automatic logic [TIME_WIDTH-1:0] time_step(input logic [TIME_WIDTH-1:0] dur);
        if (odds(5) || dur > 32'h1000_0000) return $urandom;
        return $urandom_range(dur / 2 + 2, dur / 4);
    endfunction

    function automatic void queue_item(input logic op, input logic [TIME_WIDTH-1:0] t,
                                       input longint acc, input longint vel,
                                       input logic [STG_WIDTH-1:0] stg);
        t_item it;
        it.op        = op;
        it.time_us   = t;
        it.accel_z   = acc[ACC_WIDTH-1:0];
        it.vel_z     = vel[ACC_WIDTH-1:0];
        it.new_stage = stg;
        flight_items_q.push_back(it);
    endfunction

    function automatic void queue_force(input logic [STG_WIDTH-1:0] stg);
        queue_item(OP_FORCE, $urandom, any_value(), any_value(), stg);
    endfunction

    function automatic void queue_noise();
        t_item      it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_item)-1:0];
        flight_items_q.push_back(it);
    endfunction

    // one sample on the flight time base, now and then preceded by a stray force
    function automatic void queue_sample(input longint acc, input longint vel,
                                         input logic [TIME_WIDTH-1:0] dur);
        if (odds(4)) queue_force(STG_WIDTH'($urandom_range(7)));
        mission_us += time_step(dur);
        queue_item(OP_SAMPLE, mission_us, acc, vel, STG_WIDTH'($urandom_range(7)));
    endfunction

    // a well-formed flight from the pad to touchdown, with mostly qualifying samples in the timed phases
    function automatic void queue_flight();
        longint boost_thr, burn_thr, apo, desc, land;
        boost_thr = $signed(limits.boost_accel);
        burn_thr  = $signed(limits.burnout_accel);
        apo       = limits.apogee_speed;
        desc      = $signed(limits.descent_speed);
        land      = limits.landing_speed;
        queue_force(ST_PAD);
        repeat ($urandom_range(6, 2))
            queue_sample(odds(80) ? accel_over(boost_thr) : accel_not_over(boost_thr),
                         any_value(), limits.liftoff_time);
        repeat ($urandom_range(6, 2))
            queue_sample(odds(80) ? accel_not_over(burn_thr) : accel_over(burn_thr),
                         any_value(), limits.burnout_time);
        repeat ($urandom_range(6, 2))
            queue_sample(any_value(), odds(35) ? vel_slow(apo) : vel_fast(apo), 32'd1000);
        repeat ($urandom_range(5, 2))
            queue_sample(any_value(), odds(40) ? vel_below(desc) : vel_not_below(desc),
                         32'd1000);
        repeat ($urandom_range(6, 2))
            queue_sample(any_value(), odds(80) ? vel_slow(land) : vel_fast(land),
                         limits.landing_time);
        repeat ($urandom_range(2))
            queue_sample(any_value(), any_value(), 32'd1000);
        repeat ($urandom_range(3)) queue_noise();
    endfunction

    function automatic logic [TIME_WIDTH-1:0] rand_duration();
        if (odds(50)) return $urandom_range(5000);
        if (odds(50)) return $urandom;
        return '0;
    endfunction

    // threshold set for a phase: two extreme corners, the reset set, else random
    function automatic t_cfg pick_thresholds(input int ph);
        t_cfg c;
        case (ph)
            2: begin
                c = '{boost_accel: 24'sh7FFFFF, liftoff_time: 32'd0,
                      burnout_accel: 24'sh800000, burnout_time: 32'd0,
                      apogee_speed: 23'd0, descent_speed: 24'sh800000,
                      landing_speed: 23'h7FFFFF, landing_time: 32'd0};
            end
            3: begin
                c = '{boost_accel: 24'sh800000, liftoff_time: 32'hFFFF_FFFF,
                      burnout_accel: 24'sh7FFFFF, burnout_time: 32'hFFFF_FFFF,
                      apogee_speed: 23'h7FFFFF, descent_speed: 24'sh7FFFFF,
                      landing_speed: 23'd0, landing_time: 32'hFFFF_FFFF};
            end
            4: begin
                c = '{boost_accel: 24'sd7680, liftoff_time: 32'd100000,
                      burnout_accel: 24'sd0, burnout_time: 32'd100000,
                      apogee_speed: 23'd512, descent_speed: -24'sd512,
                      landing_speed: 23'd256, landing_time: 32'd2000000};
            end
            default: begin
                c.boost_accel   = ACC_WIDTH'(odds(60) ? pick_span(-4096, 16384) : any_value());
                c.burnout_accel = ACC_WIDTH'(odds(60) ? pick_span(-2048, 2048) : any_value());
                c.apogee_speed  = SPD_WIDTH'(odds(60) ? $urandom_range(2048) : $urandom);
                c.descent_speed = ACC_WIDTH'(odds(60) ? pick_span(-2048, 256) : any_value());
                c.landing_speed = SPD_WIDTH'(odds(60) ? $urandom_range(1024) : $urandom);
                c.liftoff_time  = (ph == 1) ? $urandom_range(5000) : rand_duration();
                c.burnout_time  = (ph == 1) ? $urandom_range(5000) : rand_duration();
                c.landing_time  = (ph == 1) ? $urandom_range(5000) : rand_duration();
            end
        endcase
        return c;
    endfunction

    // predictor: next stage and change flag for one accepted item
    task automatic track_stage(input t_item it);
        logic [STG_WIDTH-1:0]  nxt;
        logic [TIME_WIDTH-1:0] since;
        int                    acc, vel, speed;
        t_stage_report         rep;
        acc   = int'($signed(it.accel_z));
        vel   = int'($signed(it.vel_z));
        speed = (vel < 0) ? -vel : vel;
        nxt   = stage_now;
        if (it.op == OP_FORCE) begin
            if (it.new_stage <= ST_LANDED) nxt = it.new_stage;
        end else begin
            case (stage_now)
                ST_PAD: begin
                    if (acc > int'($signed(limits.boost_accel))) begin
                        since = it.time_us - boost_t0;
                        if (!boost_armed) begin
                            boost_t0    = it.time_us;
                            boost_armed = 1'b1;
                        end else if (since > limits.liftoff_time) begin
                            nxt = ST_BOOST;
                        end
                    end
                end
                ST_BOOST: begin
                    if (acc <= int'($signed(limits.burnout_accel))) begin
                        since = it.time_us - burnout_t0;
                        if (!burnout_armed) begin
                            burnout_t0    = it.time_us;
                            burnout_armed = 1'b1;
                        end else if (since > limits.burnout_time) begin
                            nxt = ST_COAST;
                        end
                    end
                end
                ST_COAST: begin
                    if (speed < int'(limits.apogee_speed)) nxt = ST_APOGEE;
                end
                ST_APOGEE: begin
                    if (vel < int'($signed(limits.descent_speed))) nxt = ST_DESCENT;
                end
                ST_DESCENT: begin
                    if (speed < int'(limits.landing_speed)) begin
                        since = it.time_us - touchdown_t0;
                        if (!touchdown_armed) begin
                            touchdown_t0    = it.time_us;
                            touchdown_armed = 1'b1;
                        end else if (since > limits.landing_time) begin
                            nxt = ST_LANDED;
                        end
                    end
                end
                default: ;
            endcase
        end
        rep.stage   = nxt;
        rep.changed = (nxt != stage_now);
        stage_now   = nxt;
        stage_reports_q.push_back(rep);
    endtask

    // sender: offers queued items, predicts each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_stage(item_on_bus);
                items_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (flight_items_q.size() > 0 && (no_gaps || odds(90))) begin
                    item_on_bus = flight_items_q.pop_front();
                    i_op        <= item_on_bus.op;
                    i_time_us   <= item_on_bus.time_us;
                    i_accel_z   <= item_on_bus.accel_z;
                    i_vel_z     <= item_on_bus.vel_z;
                    i_new_stage <= item_on_bus.new_stage;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random back-pressure, each result checked against the oldest prediction
    always @(posedge i_clk) begin
        t_stage_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                stages_reached[o_stage] = 1'b1;
                if (o_changed === 1'b1) stage_changes++;
                if (stage_reports_q.size() == 0) begin
                    $display("%0t: unexpected result, stage %0d changed %0d",
                             $time, o_stage, o_changed);
                    mismatch_count++;
                end else begin
                    want = stage_reports_q.pop_front();
                    if (o_stage !== want.stage) begin
                        $display("%0t: stage mismatch, expected %0d, got %0d",
                                 $time, want.stage, o_stage);
                        mismatch_count++;
                    end
                    if (o_changed !== want.changed) begin
                        $display("%0t: changed flag mismatch, expected %0d, got %0d",
                                 $time, want.changed, o_changed);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= no_gaps || odds(90);
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, stage_reports_q.size());
            $display("** flight_stage_detector_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [DAT_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
    endtask

    task automatic load_thresholds(input t_cfg c);
        limits = c;
        write_reg(REG_BOOST_ACCEL,   {8'd0, c.boost_accel});
        write_reg(REG_LIFTOFF_TIME,  c.liftoff_time);
        write_reg(REG_BURNOUT_ACCEL, {8'd0, c.burnout_accel});
        write_reg(REG_BURNOUT_TIME,  c.burnout_time);
        write_reg(REG_APOGEE_SPEED,  {9'd0, c.apogee_speed});
        write_reg(REG_DESCENT_SPEED, {8'd0, c.descent_speed});
        write_reg(REG_LANDING_SPEED, {9'd0, c.landing_speed});
        write_reg(REG_LANDING_TIME,  c.landing_time);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold off until every item is taken and every result is back
    task automatic wait_quiet();
        @(posedge i_clk);
        while (flight_items_q.size() > 0 || i_in_valid || stage_reports_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // scripted flight on reset thresholds, walking every boundary and wrap
    function automatic void queue_scripted_flight();
        queue_item(OP_SAMPLE, 32'd0, VAL_MAX, VAL_MAX, ST_PAD);
        queue_force(ST_NO_SUCH);
        queue_force(ST_UNINIT);
        queue_force(ST_PAD);
        queue_force(ST_PAD);
        queue_item(OP_SAMPLE, 32'd1000, 7680, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd1000, 7681, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd101000, VAL_MAX, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd101001, 7681, 0, ST_NO_SUCH);
        queue_item(OP_SAMPLE, 32'hFFFF_FF00, 1, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'hFFFF_FF00, VAL_MIN, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'hFFFF_FF00 + 32'd100001, 0, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd200, 0, VAL_MIN, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd300, 0, 512, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd400, 0, -511, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd500, 0, -512, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd600, 0, -513, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd700, 0, VAL_MIN, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd5, 0, 255, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd2000005, 0, -255, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'd2000006, 0, 0, ST_UNINIT);
        queue_item(OP_SAMPLE, 32'hFFFF_FFFF, VAL_MIN, 0, ST_UNINIT);
        queue_force(ST_NO_SUCH);
        queue_force(ST_COAST);
        queue_force(ST_BOOST);
        queue_force(ST_APOGEE);
        queue_force(ST_DESCENT);
        queue_force(ST_LANDED);
    endfunction

    // phases: scripted flight, then random flights under seven threshold sets
    initial begin
        limits = '{boost_accel: 24'sd7680, liftoff_time: 32'd100000,
                   burnout_accel: 24'sd0, burnout_time: 32'd100000,
                   apogee_speed: 23'd512, descent_speed: -24'sd512,
                   landing_speed: 23'd256, landing_time: 32'd2000000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_scripted_flight();
        wait_quiet();
        for (int ph = 1; ph <= 7; ph++) begin
            load_thresholds(pick_thresholds(ph));
            no_gaps = (ph == 4);
            for (int f = 0; f < 8; f++) begin
                queue_flight();
                if (ph == 5 && f == 3) wait_quiet();
            end
            wait_quiet();
        end
        repeat (8) @(posedge i_clk);
        $display("run: %0d items taken, %0d results checked, %0d stage changes",
                 items_taken, results_checked, stage_changes);
        $display("run: stages reported %b, seven threshold sets incl. both extremes",
                 stages_reached);
        if (mismatch_count == 0 && stage_reports_q.size() == 0) begin
            $display("** flight_stage_detector_top: PASSED **");
        end else begin
            $display("** flight_stage_detector_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fsd_pkg.sv
src/fsd_cfg.sv
src/fsd_core.sv
src/flight_stage_detector_top.sv
bench/tb.sv
